FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the ready queue sequencer rqr_seq
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/rqr_pkg.sv
// ----------------------------------------------------------------------------
// rqr_pkg
// shared types and constants of the ready queue with removal
// ----------------------------------------------------------------------------
package rqr_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TID_W   = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned QCNT_W  = 5;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ID_BITS     = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_YIELD = 2'd1,
    FUNC_TERM  = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_NULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_YIELD,
    S_SEARCH,
    S_SHIFT
  } state_e;

endpackage

FILE: src/rqr_ram.sv
// ----------------------------------------------------------------------------
// rqr_ram
// identifier store, one write port and one registered read port
// ----------------------------------------------------------------------------
module rqr_ram #(
  parameter int unsigned DEPTH = rqr_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned WIDTH = rqr_pkg::DEF_ID_BITS,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rqr_seq.sv
// ----------------------------------------------------------------------------
// rqr_seq
// request sequencer: head/count bookkeeping, search and compaction walk
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rqr_seq #(
  parameter int unsigned QUEUE_DEPTH = rqr_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = rqr_pkg::DEF_ID_BITS,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rqr_pkg::FUNC_W-1:0]  func_i,
  input  logic [rqr_pkg::TID_W-1:0]   thread_id_i,
  output logic                        done_o,
  output logic [rqr_pkg::STAT_W-1:0]  status_o,
  output logic [rqr_pkg::TID_W-1:0]   dispatched_id_o,
  output logic [rqr_pkg::QCNT_W-1:0]  queue_count_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [ID_BITS-1:0]          mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [ID_BITS-1:0]          mem_rdata_i
);

  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  rqr_pkg::state_e  state_q, state_d;
  rqr_pkg::status_e status_q, status_d;

  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      oldest_q, oldest_d;
  logic               done_q, done_d;
  logic [ID_BITS-1:0] disp_q, disp_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      rd_slot_q, rd_slot_d;
  logic [AW-1:0]      wr_slot_q, wr_slot_d;

  logic [ID_BITS-1:0] id_in;
  logic [AW:0]        tail_sum;
  logic [AW-1:0]      tail_slot;
  logic [AW-1:0]      oldest_nx;
  logic [AW-1:0]      rd_slot_nx;
  logic [CW:0]        pos_p1;
  logic [CW:0]        pos_p2;
  logic               is_last;
  logic               shift_end;

  // identifier width adaptation
  if (ID_BITS >= rqr_pkg::TID_W) begin : g_id_wide
    assign id_in = {{(ID_BITS - rqr_pkg::TID_W){1'b0}}, thread_id_i};
    assign dispatched_id_o = disp_q[rqr_pkg::TID_W-1:0];
  end else begin : g_id_narrow
    assign id_in = thread_id_i[ID_BITS-1:0];
    assign dispatched_id_o = {{(rqr_pkg::TID_W - ID_BITS){1'b0}}, disp_q};
  end

  if (CW >= rqr_pkg::QCNT_W) begin : g_cnt_wide
    assign queue_count_o = count_q[rqr_pkg::QCNT_W-1:0];
  end else begin : g_cnt_narrow
    assign queue_count_o = {{(rqr_pkg::QCNT_W - CW){1'b0}}, count_q};
  end

  // ring slot arithmetic
  assign tail_sum   = {1'b0, oldest_q} + {1'b0, count_q[AW-1:0]};
  assign tail_slot  = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
  assign oldest_nx  = ({1'b0, oldest_q} == DEPTH_W - 1'b1) ? '0 : oldest_q + 1'b1;
  assign rd_slot_nx = ({1'b0, rd_slot_q} == DEPTH_W - 1'b1) ? '0 : rd_slot_q + 1'b1;

  assign pos_p1    = {1'b0, pos_q} + (CW + 1)'(1);
  assign pos_p2    = {1'b0, pos_q} + (CW + 1)'(2);
  assign is_last   = pos_p1 >= {1'b0, count_q};
  assign shift_end = pos_p2 >= {1'b0, count_q};

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    done_d      = 1'b0;
    disp_d      = disp_q;
    id_d        = id_q;
    pos_d       = pos_q;
    rd_slot_d   = rd_slot_q;
    wr_slot_d   = wr_slot_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_slot_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = rd_slot_nx;

    unique case (state_q)
      rqr_pkg::S_IDLE: begin
        if (start) begin
          disp_d = '0;
          id_d   = id_in;
          case (func_i)
            rqr_pkg::FUNC_ADD: begin
              done_d = 1'b1;
              if (id_in == '0) begin
                status_d = rqr_pkg::STAT_NULL;
              end else if (count_q == DEPTH_C) begin
                status_d = rqr_pkg::STAT_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = tail_slot;
                mem_wdata_o = id_in;
                count_d     = count_q + 1'b1;
                status_d    = rqr_pkg::STAT_OK;
              end
            end
            rqr_pkg::FUNC_YIELD: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = rqr_pkg::STAT_EMPTY;
              end else begin
                mem_raddr_o = oldest_q;
                rd_slot_d   = oldest_q;
                state_d     = rqr_pkg::S_YIELD;
              end
            end
            rqr_pkg::FUNC_TERM: begin
              if (id_in == '0) begin
                done_d   = 1'b1;
                status_d = rqr_pkg::STAT_NULL;
              end else if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = rqr_pkg::STAT_NOT_FOUND;
              end else begin
                mem_raddr_o = oldest_q;
                rd_slot_d   = oldest_q;
                pos_d       = '0;
                state_d     = rqr_pkg::S_SEARCH;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = rqr_pkg::STAT_OK;
            end
          endcase
        end
      end

      rqr_pkg::S_YIELD: begin
        disp_d   = mem_rdata_i;
        oldest_d = oldest_nx;
        count_d  = count_q - 1'b1;
        status_d = rqr_pkg::STAT_OK;
        done_d   = 1'b1;
        state_d  = rqr_pkg::S_IDLE;
      end

      rqr_pkg::S_SEARCH: begin
        rd_slot_d = rd_slot_nx;
        if (mem_rdata_i == id_q) begin
          wr_slot_d = rd_slot_q;
          if (is_last) begin
            count_d  = count_q - 1'b1;
            status_d = rqr_pkg::STAT_OK;
            done_d   = 1'b1;
            state_d  = rqr_pkg::S_IDLE;
          end else begin
            state_d = rqr_pkg::S_SHIFT;
          end
        end else if (is_last) begin
          status_d = rqr_pkg::STAT_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = rqr_pkg::S_IDLE;
        end else begin
          pos_d = pos_p1[CW-1:0];
        end
      end

      rqr_pkg::S_SHIFT: begin
        // move entry k+1 into slot k
        mem_we_o  = 1'b1;
        wr_slot_d = rd_slot_q;
        rd_slot_d = rd_slot_nx;
        pos_d     = pos_p1[CW-1:0];
        if (shift_end) begin
          count_d  = count_q - 1'b1;
          status_d = rqr_pkg::STAT_OK;
          done_d   = 1'b1;
          state_d  = rqr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rqr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rqr_pkg::S_IDLE;
      count_q  <= '0;
      oldest_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    disp_q    <= disp_d;
    id_q      <= id_d;
    pos_q     <= pos_d;
    rd_slot_q <= rd_slot_d;
    wr_slot_q <= wr_slot_d;
  end

  assign busy     = (state_q != rqr_pkg::S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= DEPTH_C, "count above depth")
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_q, state_q == rqr_pkg::S_IDLE, "result while busy")
  `ASSERT_IMPL(a_empty_cnt, clk_i, rst_ni, done_q && status_q == rqr_pkg::STAT_EMPTY, count_q == '0 && disp_q == '0, "empty status with entries")
  `ASSERT_IMPL(a_full_cnt, clk_i, rst_ni, done_q && status_q == rqr_pkg::STAT_FULL, count_q == DEPTH_C, "full status below depth")
  `ASSERT_IMPL(a_shift_range, clk_i, rst_ni, state_q == rqr_pkg::S_SHIFT, pos_p1 < {1'b0, count_q}, "shift past last entry")

endmodule

FILE: src/ready_queue_with_removal.sv
// ----------------------------------------------------------------------------
// ready_queue_with_removal
// fifo ready queue of thread ids with add, yield and terminate requests
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done_o high and cannot be
// held off. Add, null and empty/full cases give the result in the cycle after
// the request. Yield reads the oldest entry from the id store in the S_YIELD
// state before giving its result. Terminate walks the queue one entry per cycle
// through the single read port of the id store, comparing from the oldest
// entry in S_SEARCH and then moving each later entry down one slot in S_SHIFT.
// busy is high while a yield or terminate is in progress.
module ready_queue_with_removal #(
  parameter int unsigned QUEUE_DEPTH = rqr_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = rqr_pkg::DEF_ID_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rqr_pkg::FUNC_W-1:0]  func_i,
  input  logic [rqr_pkg::TID_W-1:0]   thread_id_i,
  output logic                        done_o,
  output logic [rqr_pkg::STAT_W-1:0]  status_o,
  output logic [rqr_pkg::TID_W-1:0]   dispatched_id_o,
  output logic [rqr_pkg::QCNT_W-1:0]  queue_count_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ID_BITS-1:0] mem_rdata;

  rqr_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .thread_id_i     (thread_id_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .dispatched_id_o (dispatched_id_o),
    .queue_count_o   (queue_count_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  rqr_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
